// ----- design/tdwl_pkg.sv -----
// Package for the task delay wakeup list: widths, defaults, result kinds and
// controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tdwl_pkg;

    localparam int MAX_TASKS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int TASK_W  = 3;
    localparam int DELAY_W = 16;
    localparam int KIND_W  = 2;
    localparam int WCNT_W  = 4;

    typedef enum logic {
        OP_DELAY = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPT  = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- design/task_delay_wakeup_list.sv -----
// Top level of the task delay wakeup list: entry memory, release buffer and
// the tick walk controller. Depends on tdwl_pkg.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  request | s_valid s_ready s_op s_task_req s_delay_ticks      | in
//  result  | m_valid m_ready m_kind m_released_task             | out
//          | m_waiting_count m_last                             |
//
// A delay request's result is registered and appears in the cycle after the accept.
// A tick walks the stored entries through the registered-read entry memory,
// compacting the ones it keeps, then emits each released task through the
// release buffer by way of the EMIT_RD and EMIT_OUT states.
// Reset clears the tick counter and the entry count; memories need no clearing.
// A stalled result holds the controller; a new beat is taken only in idle.
`timescale 1ns / 1ps
`default_nettype none
module task_delay_wakeup_list #(
    parameter int MAX_TASKS   = tdwl_pkg::MAX_TASKS_DEF,
    parameter int COUNT_WIDTH = tdwl_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_op,
    input  wire logic [tdwl_pkg::TASK_W-1:0]  s_task_req,
    input  wire logic [tdwl_pkg::DELAY_W-1:0] s_delay_ticks,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tdwl_pkg::KIND_W-1:0]       m_kind,
    output logic [tdwl_pkg::TASK_W-1:0]       m_released_task,
    output logic [tdwl_pkg::WCNT_W-1:0]       m_waiting_count,
    output logic                              m_last
);

    localparam int TW    = tdwl_pkg::TASK_W;
    localparam int DW    = tdwl_pkg::DELAY_W;
    localparam int CNTW  = $clog2(MAX_TASKS + 1);
    localparam int IDXW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ENTW  = TW + COUNT_WIDTH + 1;
    localparam int SUMW  = ((COUNT_WIDTH > DW) ? COUNT_WIDTH : DW) + 1;
    localparam int WCW   = tdwl_pkg::WCNT_W;

    tdwl_pkg::state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [CNTW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [CNTW-1:0]        rel_cnt_reg, rel_cnt_next;
    logic [CNTW-1:0]        emit_ptr_reg, emit_ptr_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   clr_reg, clr_next;

    logic                   m_valid_reg, m_valid_next;
    tdwl_pkg::kind_t        kind_reg, kind_next;
    logic [TW-1:0]          task_reg, task_next;
    logic [WCW-1:0]         wcnt_reg, wcnt_next;
    logic                   last_reg, last_next;

    logic [ENTW-1:0]        ent_mem [MAX_TASKS];
    logic [ENTW-1:0]        ent_rdata_reg;
    logic                   ent_we, ent_re;
    logic [IDXW-1:0]        ent_waddr, ent_raddr;
    logic [ENTW-1:0]        ent_wdata;

    logic [TW-1:0]          rel_mem [MAX_TASKS];
    logic [TW-1:0]          rel_rdata_reg;
    logic                   rel_we, rel_re;
    logic [IDXW-1:0]        rel_waddr, rel_raddr;

    logic                   s_fire, out_free;
    logic [SUMW-1:0]        wake_sum;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [TW-1:0]          rd_task;
    logic [COUNT_WIDTH-1:0] rd_wake;
    logic                   rd_wrapped, keep;
    logic [CNTW-1:0]        count_inc, emit_inc;

    function automatic logic [WCW-1:0] to_wcnt(input logic [CNTW-1:0] c);
        logic [CNTW+WCW-1:0] wide;
        wide = {{WCW{1'b0}}, c};
        return wide[WCW-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == tdwl_pkg::S_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign wake_sum  = SUMW'(tick_reg) + SUMW'(s_delay_ticks);
    assign tick_inc  = tick_reg + 1'b1;
    assign count_inc = CNTW'(count_reg + 1'b1);
    assign emit_inc  = CNTW'(emit_ptr_reg + 1'b1);

    assign rd_task    = ent_rdata_reg[ENTW-1 -: TW];
    assign rd_wake    = ent_rdata_reg[COUNT_WIDTH:1];
    assign rd_wrapped = ent_rdata_reg[0] && !clr_reg;
    assign keep       = (rd_wake > tick_reg) || rd_wrapped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdwl_pkg::S_IDLE;
            tick_reg    <= '0;
            count_reg   <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            rel_cnt_reg <= '0;
            emit_ptr_reg <= '0;
            rd_pend_reg <= 1'b0;
            clr_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            count_reg   <= count_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            rel_cnt_reg <= rel_cnt_next;
            emit_ptr_reg <= emit_ptr_next;
            rd_pend_reg <= rd_pend_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        task_reg <= task_next;
        wcnt_reg <= wcnt_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_rdata_reg <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rel_we) begin
            rel_mem[rel_waddr] <= rd_task;
        end
        if (rel_re) begin
            rel_rdata_reg <= rel_mem[rel_raddr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        rel_cnt_next  = rel_cnt_reg;
        emit_ptr_next = emit_ptr_reg;
        rd_pend_next  = 1'b0;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        task_next     = task_reg;
        wcnt_next     = wcnt_reg;
        last_next     = last_reg;
        ent_we        = 1'b0;
        ent_re        = 1'b0;
        ent_waddr     = count_reg[IDXW-1:0];
        ent_raddr     = rd_ptr_reg[IDXW-1:0];
        ent_wdata     = {s_task_req, wake_sum[COUNT_WIDTH-1:0],
                         |wake_sum[SUMW-1:COUNT_WIDTH]};
        rel_we        = 1'b0;
        rel_re        = 1'b0;
        rel_waddr     = rel_cnt_reg[IDXW-1:0];
        rel_raddr     = emit_ptr_reg[IDXW-1:0];

        unique case (state_reg)
            tdwl_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (s_op == tdwl_pkg::OP_DELAY) begin
                        m_valid_next = 1'b1;
                        last_next    = 1'b1;
                        if (count_reg >= CNTW'(MAX_TASKS)) begin
                            kind_next = tdwl_pkg::KIND_FULL;
                            task_next = '0;
                            wcnt_next = to_wcnt(count_reg);
                        end else begin
                            ent_we     = 1'b1;
                            count_next = count_inc;
                            kind_next  = tdwl_pkg::KIND_ACCEPT;
                            task_next  = s_task_req;
                            wcnt_next  = to_wcnt(count_inc);
                        end
                    end else begin
                        tick_next    = tick_inc;
                        clr_next     = (tick_inc == '0);
                        rd_ptr_next  = '0;
                        wr_ptr_next  = '0;
                        rel_cnt_next = '0;
                        state_next   = tdwl_pkg::S_WALK;
                    end
                end
            end
            tdwl_pkg::S_WALK: begin
                // read ahead, judge the entry read last cycle, compact kept ones
                if (rd_ptr_reg < count_reg) begin
                    ent_re       = 1'b1;
                    rd_ptr_next  = CNTW'(rd_ptr_reg + 1'b1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg) begin
                    if (keep) begin
                        ent_we      = 1'b1;
                        ent_waddr   = wr_ptr_reg[IDXW-1:0];
                        ent_wdata   = {rd_task, rd_wake, rd_wrapped};
                        wr_ptr_next = CNTW'(wr_ptr_reg + 1'b1);
                    end else begin
                        rel_we       = 1'b1;
                        rel_cnt_next = CNTW'(rel_cnt_reg + 1'b1);
                    end
                end
                if (!(rd_ptr_reg < count_reg) && !rd_pend_reg) begin
                    count_next    = wr_ptr_reg;
                    emit_ptr_next = '0;
                    if (rel_cnt_reg == '0) begin
                        m_valid_next = 1'b1;
                        kind_next    = tdwl_pkg::KIND_NONE;
                        task_next    = '0;
                        wcnt_next    = to_wcnt(wr_ptr_reg);
                        last_next    = 1'b1;
                        state_next   = tdwl_pkg::S_IDLE;
                    end else begin
                        state_next = tdwl_pkg::S_EMIT_RD;
                    end
                end
            end
            tdwl_pkg::S_EMIT_RD: begin
                rel_re     = 1'b1;
                state_next = tdwl_pkg::S_EMIT_OUT;
            end
            tdwl_pkg::S_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    kind_next     = tdwl_pkg::KIND_RELEASE;
                    task_next     = rel_rdata_reg;
                    wcnt_next     = to_wcnt(count_reg);
                    last_next     = (emit_inc == rel_cnt_reg);
                    emit_ptr_next = emit_inc;
                    state_next    = (emit_inc == rel_cnt_reg) ? tdwl_pkg::S_IDLE
                                                              : tdwl_pkg::S_EMIT_RD;
                end
            end
            default: begin
                state_next = tdwl_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_released_task = task_reg;
    assign m_waiting_count = wcnt_reg;
    assign m_last          = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_TASKS))
        else $error("entry count above list depth");

    a_walk_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdwl_pkg::S_WALK) |->
        (CNTW'(rel_cnt_reg + wr_ptr_reg + CNTW'(rd_pend_reg)) == rd_ptr_reg))
        else $error("walk lost or duplicated an entry");

    a_walk_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdwl_pkg::S_WALK) |-> !m_valid_reg)
        else $error("result pending during walk");

    a_compact_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdwl_pkg::S_WALK) |-> (wr_ptr_reg <= rd_ptr_reg))
        else $error("compaction write overtook read");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |-> (state_reg == tdwl_pkg::S_IDLE))
        else $error("final beat taken while controller busy");

endmodule
`default_nettype wire
